FILE: hw/rtl/swrl_pkg.sv
// Package for the sliding-window rate limiter: field widths, register
// indexes, the controller state type and the scan control bundle.
// Depends on nothing; every other file of the block imports it.
package swrl_pkg;

   localparam int TIME_W      = 32;
   localparam int NEXT_W      = 33;
   localparam int COUNT_OUT_W = 7;
   localparam int MAXH_W      = 7;
   localparam int SCALE_W     = 9;
   localparam int RATE_W      = MAXH_W + SCALE_W;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [SCALE_W-1:0] SCALE_FULL = SCALE_W'(256);

   localparam logic REG_MAX_PER_HOUR = 1'b0;
   localparam logic REG_RATE_SCALE   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } swrl_state_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic entry_valid;
   } swrl_scan_ctrl_type;

endpackage

FILE: hw/rtl/sliding_window_rate_limiter_unit.sv
// Top level of the sliding-window rate limiter: command port, APB register
// port, the history chain of swrl_cell instances and the swrl_scan unit.
// Depends on swrl_pkg, swrl_cell and swrl_scan.
//
// A command is taken when start is high and busy is low; busy then stays
// high through the scan and finish states, so no new command is taken
// until this one is through. The pace is set by the history chain, which
// rotates once past a single window comparator per command. The result
// beat appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, in the cycle after busy falls; there is no back-pressure, so
// the receiver must take every beat as it comes. A new command may be
// started in that same cycle.
module sliding_window_rate_limiter_unit #(
   parameter int HISTORY_DEPTH  = 64,
   parameter int WINDOW_SECONDS = 3600
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [swrl_pkg::TIME_W-1:0]       req_now,
   input  logic                              req_record,
   output logic                              rsp_valid,
   output logic                              rsp_can_release,
   output logic [swrl_pkg::COUNT_OUT_W-1:0]  rsp_count_in_window,
   output logic [swrl_pkg::NEXT_W-1:0]       rsp_next_time,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [swrl_pkg::ADDR_W-1:0]       paddr,
   input  logic [swrl_pkg::DATA_W-1:0]       pwdata,
   output logic [swrl_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import swrl_pkg::*;

   localparam int CW    = $clog2(HISTORY_DEPTH + 1);
   localparam int IW    = $clog2(HISTORY_DEPTH);
   localparam int CMP_W = (CW + 8 > RATE_W) ? CW + 8 : RATE_W;
   localparam logic [NEXT_W-1:0] WINDOW = NEXT_W'(WINDOW_SECONDS);

   swrl_state_type state_ff;
   swrl_state_type state_in;

   logic [MAXH_W-1:0]  max_per_hour_ff;
   logic [MAXH_W-1:0]  max_per_hour_in;
   logic [SCALE_W-1:0] rate_scale_ff;
   logic [SCALE_W-1:0] rate_scale_in;
   logic [RATE_W-1:0]  rate_ff;
   logic [RATE_W-1:0]  rate_in;
   logic               cfg_write;

   logic [TIME_W-1:0]  now_ff;
   logic [TIME_W-1:0]  now_in;
   logic               record_ff;
   logic               record_in;
   logic [IW-1:0]      scan_idx_ff;
   logic [IW-1:0]      scan_idx_in;
   logic [CW-1:0]      stored_count_ff;
   logic [CW-1:0]      stored_count_in;

   logic               accept;
   logic               scan_last;
   logic               chain_load;
   logic               do_insert;
   swrl_scan_ctrl_type scan_ctrl;

   logic [TIME_W-1:0]  cell_q [HISTORY_DEPTH];
   logic [TIME_W-1:0]  cell_d [HISTORY_DEPTH];

   logic [CW-1:0]      win_count;
   logic [TIME_W-1:0]  win_oldest;
   logic               capacity;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_can_release_ff;
   logic                   rsp_can_release_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_in;
   logic [NEXT_W-1:0]      rsp_next_time_ff;
   logic [NEXT_W-1:0]      rsp_next_time_in;

   // Register port.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      max_per_hour_in = max_per_hour_ff;
      rate_scale_in   = rate_scale_ff;
      if (cfg_write) begin
         case (paddr[2])
            REG_MAX_PER_HOUR: max_per_hour_in = pwdata[MAXH_W-1:0];
            REG_RATE_SCALE: begin
               rate_scale_in = (pwdata[SCALE_W-1:0] > SCALE_FULL) ?
                               SCALE_FULL : pwdata[SCALE_W-1:0];
            end
            default: max_per_hour_in = max_per_hour_ff;
         endcase
      end
      rate_in = RATE_W'(max_per_hour_ff) * RATE_W'(rate_scale_ff);
   end

   always_comb begin
      case (paddr[2])
         REG_MAX_PER_HOUR: prdata = DATA_W'(max_per_hour_ff);
         REG_RATE_SCALE:   prdata = DATA_W'(rate_scale_ff);
         default:          prdata = '0;
      endcase
   end

   // Controller.
   assign accept    = start && (state_ff == ST_IDLE);
   assign scan_last = (scan_idx_ff == IW'(HISTORY_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_SCAN;
         ST_SCAN:   if (scan_last) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy                  = 1'b0;
      scan_ctrl.clear       = 1'b0;
      scan_ctrl.step        = 1'b0;
      do_insert             = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            scan_ctrl.clear = start;
         end
         ST_SCAN: begin
            busy           = 1'b1;
            scan_ctrl.step = 1'b1;
         end
         ST_FINISH: begin
            busy      = 1'b1;
            do_insert = record_ff;
         end
         default: busy = 1'b0;
      endcase
      scan_ctrl.entry_valid = ((CW+1)'(scan_idx_ff) + (CW+1)'(stored_count_ff))
                              >= (CW+1)'(HISTORY_DEPTH);
   end

   always_comb begin
      now_in          = accept ? req_now : now_ff;
      record_in       = accept ? req_record : record_ff;
      scan_idx_in     = scan_ctrl.step ? scan_idx_ff + IW'(1) : '0;
      stored_count_in = stored_count_ff;
      if (do_insert && (stored_count_ff < CW'(HISTORY_DEPTH))) begin
         stored_count_in = stored_count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         max_per_hour_ff <= '0;
         rate_scale_ff   <= SCALE_FULL;
         stored_count_ff <= '0;
         scan_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         max_per_hour_ff <= max_per_hour_in;
         rate_scale_ff   <= rate_scale_in;
         stored_count_ff <= stored_count_in;
         scan_idx_ff     <= scan_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff            <= rate_in;
      now_ff             <= now_in;
      record_ff          <= record_in;
      rsp_can_release_ff <= rsp_can_release_in;
      rsp_count_ff       <= rsp_count_in;
      rsp_next_time_ff   <= rsp_next_time_in;
   end

   // History chain. The newest event sits in cell 0; a full rotation during
   // the scan brings every cell back to where it started.
   assign chain_load = scan_ctrl.step || do_insert;

   always_comb begin
      cell_d[0] = scan_ctrl.step ? cell_q[HISTORY_DEPTH-1] : now_ff;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         cell_d[i] = cell_q[i-1];
      end
   end

   for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      swrl_cell u_cell (
         .clock (clock),
         .load  (chain_load),
         .d_in  (cell_d[g]),
         .q_out (cell_q[g])
      );
   end

   swrl_scan #(
      .HISTORY_DEPTH  (HISTORY_DEPTH),
      .WINDOW_SECONDS (WINDOW_SECONDS)
   ) u_scan (
      .clock      (clock),
      .ctrl       (scan_ctrl),
      .now        (now_ff),
      .entry_time (cell_q[HISTORY_DEPTH-1]),
      .count      (win_count),
      .oldest     (win_oldest)
   );

   // Result beat.
   always_comb begin
      capacity           = CMP_W'({win_count, 8'd0}) < CMP_W'(rate_ff);
      rsp_valid_in       = (state_ff == ST_FINISH);
      rsp_can_release_in = capacity;
      rsp_count_in       = COUNT_OUT_W'(win_count);
      if (rate_ff == '0) begin
         rsp_next_time_in = {1'b0, now_ff} + WINDOW;
      end else if (capacity) begin
         rsp_next_time_in = {1'b0, now_ff};
      end else begin
         rsp_next_time_in = {1'b0, win_oldest} + WINDOW;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_can_release     = rsp_can_release_ff;
   assign rsp_count_in_window = rsp_count_ff;
   assign rsp_next_time       = rsp_next_time_ff;

endmodule

FILE: hw/rtl/swrl_cell.sv
// One cell of the timestamp history chain: holds one stored event time and
// takes its neighbor's time whenever the chain moves.
// Depends on swrl_pkg.
module swrl_cell (
   input  logic                        clock,
   input  logic                        load,
   input  logic [swrl_pkg::TIME_W-1:0] d_in,
   output logic [swrl_pkg::TIME_W-1:0] q_out
);
   import swrl_pkg::*;

   logic [TIME_W-1:0] time_ff;
   logic [TIME_W-1:0] time_in;

   always_comb begin
      time_in = load ? d_in : time_ff;
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
   end

   assign q_out = time_ff;

endmodule

FILE: hw/rtl/swrl_scan.sv
// Window scanner at the end of the history chain: while step is high, tests
// one stored time per cycle against the window; keeps in-window count, oldest.
// Depends on swrl_pkg.
module swrl_scan #(
   parameter int HISTORY_DEPTH  = 64,
   parameter int WINDOW_SECONDS = 3600
) (
   input  logic                                    clock,
   input  swrl_pkg::swrl_scan_ctrl_type            ctrl,
   input  logic [swrl_pkg::TIME_W-1:0]             now,
   input  logic [swrl_pkg::TIME_W-1:0]             entry_time,
   output logic [$clog2(HISTORY_DEPTH+1)-1:0]      count,
   output logic [swrl_pkg::TIME_W-1:0]             oldest
);
   import swrl_pkg::*;

   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [NEXT_W-1:0] WINDOW = NEXT_W'(WINDOW_SECONDS);

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [TIME_W-1:0] oldest_ff;
   logic [TIME_W-1:0] oldest_in;
   logic              have_ff;
   logic              have_in;
   logic              in_window;

   always_comb begin
      in_window = ({1'b0, entry_time} + WINDOW) >= {1'b0, now};
      count_in  = count_ff;
      oldest_in = oldest_ff;
      have_in   = have_ff;
      if (ctrl.clear) begin
         count_in = '0;
         have_in  = 1'b0;
      end else if (ctrl.step && ctrl.entry_valid && in_window) begin
         count_in = count_ff + CW'(1);
         have_in  = 1'b1;
         if (!have_ff || (entry_time < oldest_ff)) begin
            oldest_in = entry_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      oldest_ff <= oldest_in;
      have_ff   <= have_in;
   end

   assign count  = count_ff;
   assign oldest = oldest_ff;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_rate_limiter_unit: drives command
// beats and APB register writes, predicts every result beat and compares it.
// Depends on swrl_pkg and the RTL of the unit; needs no files or arguments.

typedef struct packed {
   logic                             can_release;
   logic [swrl_pkg::COUNT_OUT_W-1:0] count_in_window;
   logic [swrl_pkg::NEXT_W-1:0]      next_time;
} release_verdict_type;

class release_verdict_board;
   localparam int HISTORY = 64;
   localparam int WINDOW  = 3600;

   logic [swrl_pkg::TIME_W-1:0]  departure_log[HISTORY];
   int unsigned                  write_slot;
   int unsigned                  stored_count;
   logic [swrl_pkg::MAXH_W-1:0]  max_per_hour;
   logic [swrl_pkg::SCALE_W-1:0] rate_scale;
   release_verdict_type          pending_verdicts[$];
   int unsigned                  errors;
   int unsigned                  checked;
   int unsigned                  peak_count;
   bit                           saw_release;
   bit                           saw_hold;

   function new();
      write_slot   = 0;
      stored_count = 0;
      max_per_hour = '0;
      rate_scale   = swrl_pkg::SCALE_FULL;
      errors       = 0;
      checked      = 0;
      peak_count   = 0;
      saw_release  = 0;
      saw_hold     = 0;
   endfunction

   function void write_reg(logic idx, logic [31:0] data);
      if (idx == swrl_pkg::REG_MAX_PER_HOUR) begin
         max_per_hour = data[swrl_pkg::MAXH_W-1:0];
      end else begin
         rate_scale = (data[swrl_pkg::SCALE_W-1:0] > swrl_pkg::SCALE_FULL) ?
                      swrl_pkg::SCALE_FULL : data[swrl_pkg::SCALE_W-1:0];
      end
   endfunction

   function int pending();
      return pending_verdicts.size();
   endfunction

   // Computes the verdict for one query, then logs the departure if asked.
   function void predict_release(logic [31:0] now, logic record);
      logic [32:0]         now_w;
      logic [32:0]         oldest;
      logic [32:0]         stamp;
      bit                  have_oldest;
      bit                  capacity;
      int unsigned         rate;
      int unsigned         count;
      release_verdict_type verdict;
      now_w       = {1'b0, now};
      oldest      = '0;
      have_oldest = 0;
      count       = 0;
      rate        = max_per_hour * rate_scale;
      for (int i = 0; i < HISTORY; i++) begin
         if (i < stored_count) begin
            stamp = {1'b0, departure_log[i]};
            if (stamp + 33'(WINDOW) >= now_w) begin
               count++;
               if (!have_oldest || stamp < oldest) begin
                  oldest      = stamp;
                  have_oldest = 1;
               end
            end
         end
      end
      capacity = (count * 256) < rate;
      verdict.can_release     = capacity;
      verdict.count_in_window = count[swrl_pkg::COUNT_OUT_W-1:0];
      if (rate == 0) begin
         verdict.next_time = now_w + 33'(WINDOW);
      end else if (capacity) begin
         verdict.next_time = now_w;
      end else begin
         verdict.next_time = oldest + 33'(WINDOW);
      end
      pending_verdicts = {pending_verdicts, verdict};
      if (count > peak_count) peak_count = count;
      if (capacity) saw_release = 1;
      else saw_hold = 1;
      if (record) begin
         departure_log[write_slot] = now;
         write_slot = (write_slot + 1) % HISTORY;
         if (stored_count < HISTORY) stored_count++;
      end
   endfunction

   function void check_verdict(logic can_release, logic [6:0] count_in_window,
                               logic [32:0] next_time);
      release_verdict_type want;
      if (pending_verdicts.size() == 0) begin
         $display("%0t: result beat with no command outstanding", $time);
         errors++;
         return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      if (can_release !== want.can_release) begin
         $display("%0t: can_release expected %0d, got %0d", $time,
                  want.can_release, can_release);
         errors++;
      end
      if (count_in_window !== want.count_in_window) begin
         $display("%0t: count_in_window expected %0d, got %0d", $time,
                  want.count_in_window, count_in_window);
         errors++;
      end
      if (next_time !== want.next_time) begin
         $display("%0t: next_time expected 0x%09h, got 0x%09h", $time,
                  want.next_time, next_time);
         errors++;
      end
   endfunction
endclass

module testbench;
   import swrl_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [TIME_W-1:0]      req_now;
   logic                   req_record;
   logic                   rsp_valid;
   logic                   rsp_can_release;
   logic [COUNT_OUT_W-1:0] rsp_count_in_window;
   logic [NEXT_W-1:0]      rsp_next_time;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [ADDR_W-1:0]      paddr;
   logic [DATA_W-1:0]      pwdata;
   logic [DATA_W-1:0]      prdata;
   logic                   pready;

   release_verdict_board board;
   logic [31:0]          sim_clock_s;
   int unsigned          commands;
   int unsigned          settings;
   int unsigned          table_maxh[6]  = '{64, 3, 40, 127, 1, 0};
   int unsigned          table_scale[6] = '{256, 128, 300, 511, 1, 256};
   int unsigned          idle_pct[3]    = '{0, 61, 31};

   sliding_window_rate_limiter_unit uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_now             (req_now),
      .req_record          (req_record),
      .rsp_valid           (rsp_valid),
      .rsp_can_release     (rsp_can_release),
      .rsp_count_in_window (rsp_count_in_window),
      .rsp_next_time       (rsp_next_time),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("** sliding_window_rate_limiter_unit: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_verdict(rsp_can_release, rsp_count_in_window, rsp_next_time);
      end
   end

   task automatic send_query(logic [31:0] now, logic record, int unsigned pct);
      @(negedge clock);
      if (pct != 0 && $urandom_range(99) < pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 70)) @(negedge clock);
      end
      start      = 1'b1;
      req_now    = now;
      req_record = record;
      do begin
         @(posedge clock);
      end while (busy);
      board.predict_release(now, record);
      commands++;
   endtask

   task automatic drain_verdicts();
      @(negedge clock);
      start = 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_limit_reg(logic idx, int unsigned value);
      logic [31:0] data;
      data = (idx == REG_MAX_PER_HOUR) ? 32'hFFFF_FF80 : 32'hFFFF_FE00;
      data = ($urandom & data) | value;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ADDR_W'({idx, 2'b00});
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      board.write_reg(idx, data);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_limits(int unsigned maxh, int unsigned scale);
      write_limit_reg(REG_MAX_PER_HOUR, maxh);
      write_limit_reg(REG_RATE_SCALE, scale);
      settings++;
   endtask

   task automatic run_phase(int unsigned items, int unsigned pct);
      int unsigned sel;
      for (int n = 0; n < items; n++) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            sim_clock_s = sim_clock_s + $urandom_range(0, 90);
         end else if (sel < 85) begin
            sim_clock_s = sim_clock_s + $urandom_range(91, 5000);
         end else if (sel < 92) begin
            sim_clock_s = sim_clock_s - $urandom_range(1, 4000);
         end else if (sel < 96) begin
            sim_clock_s = $urandom;
         end else begin
            sim_clock_s = 32'hFFFF_FFFF - $urandom_range(0, 20000);
         end
         send_query(sim_clock_s, $urandom_range(99) < 60, pct);
         if ($urandom_range(199) == 0) drain_verdicts();
      end
   endtask

   initial begin
      board       = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_now     = '0;
      req_record  = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      commands    = 0;
      settings    = 0;
      sim_clock_s = 32'd100;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero rate after reset; queries step past the window of early departures.
      send_query(32'd0, 1'b1, 0);
      send_query(32'd100, 1'b1, 0);
      send_query(32'd3600, 1'b0, 0);
      send_query(32'd3601, 1'b0, 0);
      send_query(32'd5000, 1'b0, 0);
      send_query(32'hFFFF_FFFF, 1'b1, 0);
      send_query(32'd0, 1'b0, 0);
      drain_verdicts();

      // Scale above full is clamped, and departures near the top of time carry.
      set_limits(2, 511);
      send_query(32'hFFFF_FFFF, 1'b0, 0);
      send_query(32'hFFFF_FFFF, 1'b1, 0);
      send_query(32'hFFFF_FFFF, 1'b0, 0);
      send_query(32'hFFFF_F000, 1'b0, 0);
      drain_verdicts();

      set_limits(127, 0);
      send_query(32'h8000_0000, 1'b1, 0);
      send_query(32'h7FFF_FFFF, 1'b0, 0);
      drain_verdicts();

      set_limits(1, 1);
      send_query(32'h5555_5555, 1'b0, 0);
      send_query(32'h5555_5555, 1'b1, 0);
      send_query(32'h5555_6364, 1'b0, 0);
      send_query(32'h5555_6365, 1'b0, 0);
      drain_verdicts();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 6) begin
            set_limits(table_maxh[phase], table_scale[phase]);
         end else begin
            set_limits($urandom_range(0, 127), $urandom_range(0, 511));
         end
         run_phase(120, idle_pct[phase % 3]);
         drain_verdicts();
      end

      repeat (80) @(posedge clock);
      $display("Run covered %0d commands and %0d checked beats over %0d limit settings.",
               commands, board.checked, settings);
      $display("Peak window count %0d; release granted %0d, release held %0d.",
               board.peak_count, board.saw_release, board.saw_hold);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("** sliding_window_rate_limiter_unit: PASSED **");
      end else begin
         $display("** sliding_window_rate_limiter_unit: FAILED **");
      end
      $finish;
   end
endmodule
